### rtl/tht_pkg.sv
package tht_pkg;

  localparam logic [2:0] ACT_CREATE     = 3'd0;
  localparam logic [2:0] ACT_CONNECT    = 3'd1;
  localparam logic [2:0] ACT_DISCONNECT = 3'd2;
  localparam logic [2:0] ACT_CLOSE      = 3'd3;
  localparam logic [2:0] ACT_SEGMENT    = 3'd4;
  localparam logic [2:0] ACT_TICK       = 3'd5;

  localparam logic [2:0] SEG_SYNACK = 3'd1;
  localparam logic [2:0] SEG_FINACK = 3'd3;

  localparam logic [1:0] OSEG_SYN = 2'd0;
  localparam logic [1:0] OSEG_FIN = 2'd2;

  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_SEG   = 2'd1;
  localparam logic [1:0] KIND_EVENT = 2'd2;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_PENDING   = 3'd1;
  localparam logic [2:0] STAT_ERROR     = 3'd2;
  localparam logic [2:0] STAT_CONNECTED = 3'd3;
  localparam logic [2:0] STAT_CLOSED    = 3'd4;
  localparam logic [2:0] STAT_FAILED    = 3'd5;

  localparam logic [1:0] ST_CLOSED    = 2'd0;
  localparam logic [1:0] ST_SYNSENT   = 2'd1;
  localparam logic [1:0] ST_CONNECTED = 2'd2;
  localparam logic [1:0] ST_FINWAIT   = 2'd3;

  localparam logic [1:0] REG_SYN_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_SYN_LIMIT   = 2'd1;
  localparam logic [1:0] REG_FIN_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_FIN_LIMIT   = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  sock_id;
    logic [15:0] local_port;
    logic [15:0] remote_port;
    logic [2:0]  seg_type;
    logic [15:0] seg_dest_port;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [1:0]  out_seg_type;
    logic [15:0] out_src_port;
    logic [15:0] out_dest_port;
    logic [1:0]  conn_state;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [15:0] local_port;
    logic [15:0] remote_port;
    logic [1:0]  state;
    logic [3:0]  tries;
    logic [15:0] timer;
  } ent_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_EXEC,
    S_FLUSH
  } fsm_t;

endpackage

### rtl/transport_handshake_table.sv
// Client connection table with SYN / FIN handshake control.
// Request channel (req_valid / req_stall / req) carries one command:
// create, connect, disconnect, close, received segment or tick.
// Response channel (rsp_valid / rsp_stall / rsp) returns zero or more
// results per request; the final one has last set.
// Config port: cfg_wr_en writes cfg_data to register cfg_index
// (timeouts and retry limits); writing only while the block is idle is
// the user's duty, as the block does not enforce it. Entry records sit in
// a single-port-write, registered-read memory; valid bits are flip-flops.
// One request is handled at a time: connect and disconnect load their
// segment from the execute state, create and close their reply from the
// hold register in the flush state. Segment lookup and tick walk the
// entries one per cycle, paced by the single memory read port. A result
// waits in the output register while the next one is staged in a hold
// register; a stalled receiver pauses the walk.
// Reset clears all valid bits and loads the register defaults
// (timeouts 1000, limits 5); no clearing pass is needed.
module transport_handshake_table
  import tht_pkg::*;
#(
  parameter int MAX_CONNS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int USABLE = (MAX_CONNS < 8) ? MAX_CONNS : 8;
  localparam int AW = (USABLE > 1) ? $clog2(USABLE) : 1;
  localparam int CW = $clog2(USABLE + 1);

  logic [15:0] syn_tmo, fin_tmo;
  logic [3:0]  syn_lim, fin_lim;

  fsm_t state, state_next;
  req_t cmd;
  logic [CW-1:0] idx;
  logic [USABLE-1:0] valid, valid_next;
  rsp_t hold;
  logic hold_v;
  rsp_t hold_last;
  logic rsp_load;

  ent_t mem [USABLE];
  ent_t ent;
  logic [AW-1:0] rd_addr, wr_addr;
  logic wr_en;
  ent_t wr_data;

  logic accept, out_free, advance, done, at_last;
  logic r1_v, r2_v;
  rsp_t r1, r2;
  logic [CW-1:0] idx_next;

  assign accept   = req_valid && !req_stall;
  assign out_free = !rsp_valid || !rsp_stall;
  assign at_last  = idx == CW'(USABLE - 1);
  assign idx_next = idx + CW'(1);
  assign advance  = (state == S_EXEC) && out_free && !done;
  assign rd_addr  = advance ? AW'(idx_next) : AW'(idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      syn_tmo <= 16'd1000;
      syn_lim <= 4'd5;
      fin_tmo <= 16'd1000;
      fin_lim <= 4'd5;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SYN_TIMEOUT: syn_tmo <= cfg_data;
        REG_SYN_LIMIT:   syn_lim <= cfg_data[3:0];
        REG_FIN_TIMEOUT: fin_tmo <= cfg_data;
        REG_FIN_LIMIT:   fin_lim <= cfg_data[3:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    ent <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_ISSUE;
      S_ISSUE: state_next = S_EXEC;
      S_EXEC:  if (out_free && done) state_next = S_FLUSH;
      S_FLUSH: if (!hold_v || out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign req_stall = state != S_IDLE;

  // one entry is examined per cycle while the receiver is not stalled;
  // results go through the hold register so the final one can be marked last
  always_comb begin
    logic [AW-1:0] free_idx;
    logic          free_hit;
    logic          ok_slot;
    logic          syn, fin;
    r1_v = 1'b0;
    r2_v = 1'b0;
    r1 = '0;
    r2 = '0;
    wr_en = 1'b0;
    wr_addr = AW'(idx);
    wr_data = ent;
    valid_next = valid;
    done = 1'b1;
    free_idx = '0;
    free_hit = 1'b0;
    for (int i = USABLE - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = AW'(i);
        free_hit = 1'b1;
      end
    end
    ok_slot = (32'(cmd.sock_id) < USABLE) && valid[AW'(idx)];
    syn = ent.state == ST_SYNSENT;
    fin = ent.state == ST_FINWAIT;
    if (state == S_EXEC && out_free) begin
      case (cmd.action)
        ACT_CREATE: begin
          r1_v = 1'b1;
          r1.kind = KIND_REPLY;
          if (free_hit) begin
            wr_en = 1'b1;
            wr_addr = free_idx;
            wr_data = '{local_port: cmd.local_port, remote_port: '0,
                        state: ST_CLOSED, tries: '0, timer: '0};
            valid_next[free_idx] = 1'b1;
            r1.status = STAT_OK;
            r1.slot = 3'(free_idx);
          end else begin
            r1.status = STAT_ERROR;
          end
        end
        ACT_CONNECT, ACT_DISCONNECT, ACT_CLOSE: begin
          r1_v = 1'b1;
          r1.kind = KIND_REPLY;
          r1.slot = cmd.sock_id;
          r1.status = STAT_ERROR;
          if (ok_slot) begin
            r1.conn_state = ent.state;
            if (cmd.action == ACT_CONNECT && ent.state == ST_CLOSED) begin
              wr_en = 1'b1;
              wr_data.remote_port = cmd.remote_port;
              wr_data.state = ST_SYNSENT;
              wr_data.tries = 4'd1;
              wr_data.timer = syn_tmo;
              r1 = '{kind: KIND_SEG, status: STAT_PENDING, slot: cmd.sock_id,
                     out_seg_type: OSEG_SYN, out_src_port: ent.local_port,
                     out_dest_port: cmd.remote_port, conn_state: ST_SYNSENT,
                     last: 1'b0};
              r2_v = 1'b1;
              r2.kind = KIND_REPLY;
              r2.status = STAT_PENDING;
              r2.slot = cmd.sock_id;
              r2.conn_state = ST_SYNSENT;
            end else if (cmd.action == ACT_DISCONNECT &&
                         ent.state == ST_CONNECTED) begin
              wr_en = 1'b1;
              wr_data.state = ST_FINWAIT;
              wr_data.tries = 4'd1;
              wr_data.timer = fin_tmo;
              r1 = '{kind: KIND_SEG, status: STAT_PENDING, slot: cmd.sock_id,
                     out_seg_type: OSEG_FIN, out_src_port: ent.local_port,
                     out_dest_port: ent.remote_port, conn_state: ST_FINWAIT,
                     last: 1'b0};
              r2_v = 1'b1;
              r2.kind = KIND_REPLY;
              r2.status = STAT_PENDING;
              r2.slot = cmd.sock_id;
              r2.conn_state = ST_FINWAIT;
            end else if (cmd.action == ACT_CLOSE && ent.state == ST_CLOSED) begin
              valid_next[AW'(idx)] = 1'b0;
              r1.status = STAT_OK;
            end
          end
        end
        ACT_SEGMENT: begin
          if (valid[AW'(idx)] && ent.local_port == cmd.seg_dest_port) begin
            r1.kind = KIND_EVENT;
            r1.slot = 3'(idx);
            if (cmd.seg_type == SEG_SYNACK && syn) begin
              r1_v = 1'b1;
              r1.status = STAT_CONNECTED;
              r1.conn_state = ST_CONNECTED;
              wr_en = 1'b1;
              wr_data.state = ST_CONNECTED;
            end else if (cmd.seg_type == SEG_FINACK && fin) begin
              r1_v = 1'b1;
              r1.status = STAT_CLOSED;
              r1.conn_state = ST_CLOSED;
              wr_en = 1'b1;
              wr_data.state = ST_CLOSED;
            end
          end else begin
            done = at_last;
          end
        end
        ACT_TICK: begin
          done = at_last;
          if (valid[AW'(idx)] && (syn || fin)) begin
            wr_en = 1'b1;
            if (ent.timer > 16'd1) begin
              wr_data.timer = ent.timer - 16'd1;
            end else if (ent.tries < (syn ? syn_lim : fin_lim)) begin
              wr_data.tries = ent.tries + 4'd1;
              wr_data.timer = syn ? syn_tmo : fin_tmo;
              r1_v = 1'b1;
              r1 = '{kind: KIND_SEG, status: STAT_PENDING, slot: 3'(idx),
                     out_seg_type: syn ? OSEG_SYN : OSEG_FIN,
                     out_src_port: ent.local_port, out_dest_port: ent.remote_port,
                     conn_state: ent.state, last: 1'b0};
            end else begin
              wr_data.state = ST_CLOSED;
              wr_data.timer = '0;
              r1_v = 1'b1;
              r1.kind = KIND_EVENT;
              r1.status = STAT_FAILED;
              r1.slot = 3'(idx);
              r1.conn_state = ST_CLOSED;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    hold_last = hold;
    hold_last.last = 1'b1;
  end

  assign rsp_load = (state == S_EXEC && out_free && r1_v && (r2_v || hold_v)) ||
                    (state == S_FLUSH && hold_v && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      hold_v <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      valid <= valid_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (out_free) begin
        rsp_valid <= 1'b0;
      end
      if (state == S_EXEC && out_free) begin
        if (r1_v && r2_v) begin
          rsp <= r1;
          hold <= r2;
          hold_v <= 1'b1;
        end else if (r1_v) begin
          if (hold_v) begin
            rsp <= hold;
          end
          hold <= r1;
          hold_v <= 1'b1;
        end
      end
      if (state == S_FLUSH && hold_v && out_free) begin
        rsp <= hold_last;
        hold_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= req;
      if ((req.action == ACT_CONNECT || req.action == ACT_DISCONNECT ||
           req.action == ACT_CLOSE) && 32'(req.sock_id) < USABLE) begin
        idx <= CW'(req.sock_id);
      end else begin
        idx <= '0;
      end
    end else if (advance) begin
      idx <= idx_next;
    end
  end

  a_idle_no_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !hold_v)
    else $error("hold register occupied while idle");

  a_issue_exec: assert property (@(posedge clk) disable iff (rst)
    state == S_ISSUE |=> state == S_EXEC)
    else $error("read issue not followed by execute");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |-> 32'(idx) < USABLE)
    else $error("entry index out of range");

  a_valid_step: assert property (@(posedge clk) disable iff (rst)
    state != S_EXEC |=> $stable(valid))
    else $error("valid bits changed outside execute");

endmodule
